// ===== rtl/lad_pkg.sv =====
`timescale 1ns / 1ps

package lad_pkg;

  // Default number of slots in the array
  localparam int DEPTH_DEFAULT = 16;

  // Field widths fixed by the command and response formats
  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int CAP_W    = 5;
  localparam int OCC_W    = 5;

  // Configuration port
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam logic CAP_WORD = 1'b0;        // word address of the capacity register
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  // Command transaction payload
  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  // Response transaction payload
  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] popped;
    logic                      now_empty;
    logic [OCC_W-1:0]          occupancy;
  } rsp_t;

  // Slot array access for one command
  typedef struct packed {
    logic wr;
    logic rd;
  } mem_op_t;

  // Registered result fields from the control block
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                now_empty;
    logic [OCC_W-1:0]    occupancy;
    logic                pop_ok;
  } result_t;

endpackage

// ===== rtl/lad_mem.sv =====
`timescale 1ns / 1ps

module lad_mem #(
  parameter int DEPTH = lad_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  lad_pkg::mem_op_t                   op,
  input  logic [$clog2(DEPTH)-1:0]           addr,
  input  logic signed [lad_pkg::VALUE_W-1:0] wdata,
  output logic signed [lad_pkg::VALUE_W-1:0] rdata
);

  logic signed [lad_pkg::VALUE_W-1:0] mem [DEPTH];

  // Write a pushed value
  always_ff @(posedge clk) begin
    if (op.wr) begin
      mem[addr] <= wdata;
    end
  end

  // Read the slot being popped
  always_ff @(posedge clk) begin
    if (op.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/lad_ctrl.sv =====
`timescale 1ns / 1ps

module lad_ctrl #(
  parameter int DEPTH = lad_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [lad_pkg::CMD_W-1:0]      cmd,
  input  logic [lad_pkg::CAP_W-1:0]      capacity,
  output lad_pkg::mem_op_t               mem_op,
  output logic [$clog2(DEPTH)-1:0]       mem_addr,
  output lad_pkg::result_t               result
);

  localparam int IW = $clog2(DEPTH);
  // Compare width: holds DEPTH, the capacity field and index + 1
  localparam int CW = (IW + 1 > lad_pkg::CAP_W + 1) ? IW + 1 : lad_pkg::CAP_W + 1;

  logic [IW-1:0]   head;
  logic [IW-1:0]   head_next;
  logic [IW-1:0]   tail;
  logic [IW-1:0]   tail_next;
  logic            vacant;
  logic            vacant_next;
  logic [CW-1:0]   cap_ext;
  logic [CW-1:0]   usable;
  logic            back_full;
  logic [CW-1:0]   occ_full;
  logic [lad_pkg::STATUS_W-1:0] status;
  lad_pkg::mem_op_t op;

  // Clamp the capacity to one .. DEPTH slots
  always_comb begin
    cap_ext = CW'(capacity);
    if (capacity == '0) begin
      usable = CW'(1);
    end else if (cap_ext > CW'(DEPTH)) begin
      usable = CW'(DEPTH);
    end else begin
      usable = cap_ext;
    end
  end

  assign back_full = (CW'(tail) + CW'(1)) >= usable;

  // Decode the command against the current indices
  always_comb begin
    head_next   = head;
    tail_next   = tail;
    vacant_next = vacant;
    status      = lad_pkg::ST_DONE;
    op          = '0;
    mem_addr    = head;
    unique case (cmd)
      lad_pkg::CMD_PUSH_FRONT, lad_pkg::CMD_PUSH_BACK: begin
        if (!vacant && (cmd == lad_pkg::CMD_PUSH_FRONT) && (head == '0)) begin
          status = lad_pkg::ST_OVERFLOW;
        end else if (!vacant && (cmd == lad_pkg::CMD_PUSH_BACK) && back_full) begin
          status = lad_pkg::ST_OVERFLOW;
        end else if (vacant) begin
          // first entry always lands in slot zero
          op.wr       = 1'b1;
          mem_addr    = '0;
          head_next   = '0;
          tail_next   = '0;
          vacant_next = 1'b0;
        end else if (cmd == lad_pkg::CMD_PUSH_FRONT) begin
          op.wr     = 1'b1;
          head_next = head - IW'(1);
          mem_addr  = head - IW'(1);
        end else begin
          op.wr     = 1'b1;
          tail_next = tail + IW'(1);
          mem_addr  = tail + IW'(1);
        end
      end
      lad_pkg::CMD_POP_FRONT, lad_pkg::CMD_POP_BACK: begin
        if (vacant) begin
          status = lad_pkg::ST_UNDERFLOW;
        end else begin
          op.rd    = 1'b1;
          mem_addr = (cmd == lad_pkg::CMD_POP_FRONT) ? head : tail;
          if (head == tail) begin
            // last entry leaves: return both indices to slot zero
            head_next   = '0;
            tail_next   = '0;
            vacant_next = 1'b1;
          end else if (cmd == lad_pkg::CMD_POP_FRONT) begin
            head_next = head + IW'(1);
          end else begin
            tail_next = tail - IW'(1);
          end
        end
      end
      default: begin
        status = lad_pkg::ST_DONE;
      end
    endcase
  end

  assign occ_full = vacant_next ? '0 : (CW'(tail_next) - CW'(head_next) + CW'(1));

  // Gate the array access with the transaction
  assign mem_op.wr = accept & op.wr;
  assign mem_op.rd = accept & op.rd;

  // Advance the indices
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= '0;
      vacant <= 1'b1;
    end else if (accept) begin
      head   <= head_next;
      tail   <= tail_next;
      vacant <= vacant_next;
    end
  end

  // Hold the result fields for the response
  always_ff @(posedge clk) begin
    if (accept) begin
      result.status    <= status;
      result.now_empty <= vacant_next;
      result.occupancy <= occ_full[lad_pkg::OCC_W-1:0];
      result.pop_ok    <= op.rd;
    end
  end

endmodule

// ===== rtl/linear_array_deque.sv =====
`timescale 1ns / 1ps

// Double-ended queue over a fixed, non-circular array of DEPTH signed 32-bit
// slots. Each command transaction pushes or pops at the front or the back and
// returns one response transaction with the status (done, overflow,
// underflow), the popped value (zero unless a pop succeeded), the empty mark
// and the entry count after the command. One command is taken per cycle while
// cmd_ready is high; its response appears in the cycle after acceptance: the
// indices update and the slot array is written or read in the same cycle, and the
// popped value comes out of the array's read register. cmd_ready follows rsp_ready
// whenever a response is waiting. The capacity register (byte address 0, reset 16,
// clamped to 1..DEPTH) limits pushes at the back; write it only while idle.

module linear_array_deque #(
  parameter int DEPTH = lad_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  lad_pkg::cmd_t                 cmd_data,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output lad_pkg::rsp_t                 rsp_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lad_pkg::PADDR_W-1:0]   paddr,
  input  logic [lad_pkg::PDATA_W-1:0]   pwdata,
  output logic [lad_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int IW = $clog2(DEPTH);

  logic                               accept;
  logic [lad_pkg::CAP_W-1:0]          capacity;
  lad_pkg::mem_op_t                   mem_op;
  logic [IW-1:0]                      mem_addr;
  logic signed [lad_pkg::VALUE_W-1:0] rdata;
  lad_pkg::result_t                   result;

  assign cmd_ready = !rsp_valid || rsp_ready;
  assign accept    = cmd_valid && cmd_ready;

  // Capacity register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lad_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == lad_pkg::CAP_WORD)) begin
      capacity <= pwdata[lad_pkg::CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == lad_pkg::CAP_WORD) ? lad_pkg::PDATA_W'(capacity) : '0;

  lad_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .cmd      (cmd_data.cmd),
    .capacity (capacity),
    .mem_op   (mem_op),
    .mem_addr (mem_addr),
    .result   (result)
  );

  lad_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk   (clk),
    .op    (mem_op),
    .addr  (mem_addr),
    .wdata (cmd_data.value),
    .rdata (rdata)
  );

  // Track the pending response
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Assemble the response payload
  assign rsp_data.status    = result.status;
  assign rsp_data.popped    = result.pop_ok ? rdata : '0;
  assign rsp_data.now_empty = result.now_empty;
  assign rsp_data.occupancy = result.occupancy;

endmodule

// ===== rtl/lad_checker.sv =====
`timescale 1ns / 1ps

module lad_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input lad_pkg::rsp_t rsp_data
);

  // Hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response changed while stalled");

  // Answer every command transaction in the next cycle
  a_cmd_answered: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> rsp_valid)
    else $error("command without response");

  // Report underflow only on an empty deque
  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status == lad_pkg::ST_UNDERFLOW) |-> rsp_data.now_empty)
    else $error("underflow on a non-empty deque");

  // Drop the popped value on failed commands
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status != lad_pkg::ST_DONE) |-> (rsp_data.popped == '0))
    else $error("failed command returned a value");

  // Keep the count at zero when empty
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.now_empty |-> (rsp_data.occupancy == '0))
    else $error("empty deque with nonzero count");

endmodule

bind linear_array_deque lad_checker u_lad_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_data  (rsp_data)
);

// ===== sim/linear_array_deque_tb.sv =====
`timescale 1ns / 1ps

module linear_array_deque_tb;

  localparam int SLOTS       = lad_pkg::DEPTH_DEFAULT;
  localparam int STALL_LIMIT = 2000;
  localparam int NUM_PHASES  = 11;
  localparam int PHASE_ITEMS = 41;
  localparam int MAX_REPORTS = 40;

  // Command mixes for the random phases
  localparam int MIX_BALANCED = 0;
  localparam int MIX_FILL     = 1;
  localparam int MIX_DRAIN    = 2;

  localparam logic [lad_pkg::PADDR_W-1:0] CAP_ADDR =
    lad_pkg::PADDR_W'(lad_pkg::CAP_WORD) << 2;

  // Shadow copy of the deque: applies each accepted command and holds the
  // responses it should produce, oldest first.
  class deque_shadow;
    logic signed [lad_pkg::VALUE_W-1:0] slots [SLOTS];
    int unsigned head;
    int unsigned tail;
    bit vacant;
    logic [lad_pkg::CAP_W-1:0] cap;
    lad_pkg::rsp_t pending_rsp[$];
    int errors;
    int tally [4];

    function new();
      head   = 0;
      tail   = 0;
      vacant = 1'b1;
      cap    = lad_pkg::CAP_RESET;
      errors = 0;
      foreach (tally[i]) tally[i] = 0;
    endfunction

    function int unsigned usable();
      if (cap == 0) return 1;
      if (cap > SLOTS) return SLOTS;
      return 32'(cap);
    endfunction

    function void apply_cmd(lad_pkg::cmd_t c);
      lad_pkg::rsp_t want;
      bit blocked;
      want = '0;
      want.status = lad_pkg::ST_DONE;
      if (c.cmd == lad_pkg::CMD_PUSH_FRONT || c.cmd == lad_pkg::CMD_PUSH_BACK) begin
        if (c.cmd == lad_pkg::CMD_PUSH_FRONT) blocked = !vacant && head == 0;
        else blocked = !vacant && tail + 1 >= usable();
        if (blocked) begin
          want.status = lad_pkg::ST_OVERFLOW;
        end else if (vacant) begin
          slots[0] = c.value;
          head     = 0;
          tail     = 0;
          vacant   = 1'b0;
        end else if (c.cmd == lad_pkg::CMD_PUSH_FRONT) begin
          head--;
          slots[head] = c.value;
        end else begin
          tail++;
          slots[tail] = c.value;
        end
      end else if (vacant) begin
        want.status = lad_pkg::ST_UNDERFLOW;
      end else begin
        want.popped = (c.cmd == lad_pkg::CMD_POP_FRONT) ? slots[head] : slots[tail];
        if (head == tail) begin
          head   = 0;
          tail   = 0;
          vacant = 1'b1;
        end else if (c.cmd == lad_pkg::CMD_POP_FRONT) begin
          head++;
        end else begin
          tail--;
        end
      end
      want.now_empty = vacant;
      want.occupancy = vacant ? '0 : lad_pkg::OCC_W'(tail - head + 1);
      tally[want.status]++;
      pending_rsp.push_back(want);
    endfunction

    function void flag(string field, logic [lad_pkg::VALUE_W-1:0] exp_v,
                       logic [lad_pkg::VALUE_W-1:0] got_v);
      errors++;
      if (errors <= MAX_REPORTS)
        $error("%s mismatch: expected %0h, got %0h", field, exp_v, got_v);
    endfunction

    function void match_rsp(lad_pkg::rsp_t got);
      lad_pkg::rsp_t want;
      if (pending_rsp.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $error("response with nothing outstanding: %0h", got);
        return;
      end
      want = pending_rsp.pop_front();
      if (got.status !== want.status)
        flag("status", lad_pkg::VALUE_W'(want.status), lad_pkg::VALUE_W'(got.status));
      if (got.popped !== want.popped)
        flag("popped", want.popped, got.popped);
      if (got.now_empty !== want.now_empty)
        flag("now_empty", lad_pkg::VALUE_W'(want.now_empty),
             lad_pkg::VALUE_W'(got.now_empty));
      if (got.occupancy !== want.occupancy)
        flag("occupancy", lad_pkg::VALUE_W'(want.occupancy),
             lad_pkg::VALUE_W'(got.occupancy));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  lad_pkg::cmd_t cmd_data;
  logic rsp_valid;
  logic rsp_ready;
  lad_pkg::rsp_t rsp_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [lad_pkg::PADDR_W-1:0] paddr;
  logic [lad_pkg::PDATA_W-1:0] pwdata;
  logic [lad_pkg::PDATA_W-1:0] prdata;
  logic pready;

  deque_shadow shadow;
  bit quiet;
  int idle_cycles;
  int stall_left;
  int cap_writes;

  linear_array_deque u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, none while quiet
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [lad_pkg::VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'h7FFF_FFFF;
    if (r < 6) return 32'h8000_0000;
    if (r < 8) return '0;
    if (r < 10) return '1;
    return $urandom;
  endfunction

  function automatic logic [lad_pkg::CMD_W-1:0] pick_cmd(int mix);
    int unsigned r;
    int unsigned w_pf;
    int unsigned w_pb;
    int unsigned w_popf;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        w_pf = 10; w_pb = 55; w_popf = 25;
      end
      MIX_DRAIN: begin
        w_pf = 30; w_pb = 15; w_popf = 35;
      end
      default: begin
        w_pf = 25; w_pb = 25; w_popf = 25;
      end
    endcase
    if (r < w_pf) return lad_pkg::CMD_PUSH_FRONT;
    if (r < w_pf + w_pb) return lad_pkg::CMD_PUSH_BACK;
    if (r < w_pf + w_pb + w_popf) return lad_pkg::CMD_POP_FRONT;
    return lad_pkg::CMD_POP_BACK;
  endfunction

  // Present one command, hold it until taken, then idle for a random gap
  task automatic drive_cmd(input logic [lad_pkg::CMD_W-1:0] code,
                           input logic [lad_pkg::VALUE_W-1:0] val);
    int gap;
    @(negedge clk);
    cmd_valid      <= 1'b1;
    cmd_data.cmd   <= code;
    cmd_data.value <= val;
    do @(posedge clk); while (!cmd_ready);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      cmd_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid and wait for every response to drain
  task automatic drain();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (shadow.pending_rsp.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [lad_pkg::PDATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow.cap = val[lad_pkg::CAP_W-1:0];
    cap_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Response side back-pressure: random stalls with an occasional long one
  initial begin
    int unsigned r;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) stall_left = $urandom_range(8, 30);
        rsp_ready <= (r >= 25);
      end
    end
  end

  // Sample both channels at the rising edge and track forward progress
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (rsp_valid && rsp_ready) shadow.match_rsp(rsp_data);
      if (cmd_valid && cmd_ready) shadow.apply_cmd(cmd_data);
      if ((rsp_valid && rsp_ready) || (cmd_valid && cmd_ready) || (psel && penable))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [lad_pkg::CAP_W-1:0] caps [NUM_PHASES];
    int mix;
    shadow     = new();
    quiet      = 1'b0;
    cap_writes = 0;
    rst        = 1'b1;
    cmd_valid  = 1'b0;
    cmd_data   = '0;
    rsp_ready  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    caps = '{5'd16, 5'd1, 5'd0, 5'd8, 5'd31, 5'd3, 5'd16, 5'd20, 5'd5, 5'd2, 5'd16};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty pops, first push at slot 0, front blocked at slot 0, extremes
    drive_cmd(lad_pkg::CMD_POP_FRONT, 32'h1234_5678);
    drive_cmd(lad_pkg::CMD_POP_BACK, '1);
    drive_cmd(lad_pkg::CMD_PUSH_BACK, 32'h7FFF_FFFF);
    drive_cmd(lad_pkg::CMD_PUSH_FRONT, 32'h0BAD_F00D);
    drive_cmd(lad_pkg::CMD_PUSH_BACK, 32'h8000_0000);
    drive_cmd(lad_pkg::CMD_PUSH_BACK, '0);
    drive_cmd(lad_pkg::CMD_PUSH_BACK, '1);
    drive_cmd(lad_pkg::CMD_POP_FRONT, '0);
    drive_cmd(lad_pkg::CMD_POP_BACK, '0);
    drive_cmd(lad_pkg::CMD_PUSH_FRONT, 32'h5555_AAAA);
    drive_cmd(lad_pkg::CMD_POP_BACK, '0);
    drive_cmd(lad_pkg::CMD_POP_FRONT, '0);
    drive_cmd(lad_pkg::CMD_POP_FRONT, '0);
    drive_cmd(lad_pkg::CMD_PUSH_FRONT, 32'hAAAA_5555);
    drive_cmd(lad_pkg::CMD_POP_FRONT, '0);
    drain();

    // Small capacity: back fills up, freed front slot takes a push
    write_capacity(32'd2);
    drive_cmd(lad_pkg::CMD_PUSH_BACK, 32'h0000_0001);
    drive_cmd(lad_pkg::CMD_PUSH_BACK, 32'h0000_0002);
    drive_cmd(lad_pkg::CMD_PUSH_BACK, 32'h0000_0003);
    drive_cmd(lad_pkg::CMD_POP_FRONT, '0);
    drive_cmd(lad_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFE);
    drive_cmd(lad_pkg::CMD_POP_BACK, '0);
    drive_cmd(lad_pkg::CMD_POP_BACK, '0);
    drain();

    // Random phases; state carries across capacity changes
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(lad_pkg::PDATA_W'(caps[p]));
      quiet = (p % 4 == 3);
      mix   = (p == 0) ? MIX_FILL : $urandom_range(0, 2);
      for (int i = 0; i < PHASE_ITEMS; i++)
        drive_cmd(pick_cmd(mix), pick_value());
      drain();
    end

    quiet = 1'b0;
    repeat (8) @(posedge clk);
    $display("Ran %0d commands over %0d capacity writes: %0d done, %0d overflow, %0d underflow",
             shadow.tally[lad_pkg::ST_DONE] + shadow.tally[lad_pkg::ST_OVERFLOW] +
             shadow.tally[lad_pkg::ST_UNDERFLOW],
             cap_writes, shadow.tally[lad_pkg::ST_DONE], shadow.tally[lad_pkg::ST_OVERFLOW],
             shadow.tally[lad_pkg::ST_UNDERFLOW]);
    if (shadow.errors == 0 && shadow.pending_rsp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lad_pkg.sv
rtl/lad_mem.sv
rtl/lad_ctrl.sv
rtl/linear_array_deque.sv
rtl/lad_checker.sv
sim/linear_array_deque_tb.sv
